FILE: rtl/core/atrp_pkg.sv
// ----------------------------------------------------------------------------
// Tilt sensing package
// Shared types, constants and tables of the roll/pitch core.
// ----------------------------------------------------------------------------
package atrp_pkg;

    localparam int CordicStagesDefault = 16;
    localparam int AtanTableLen = 24;
    localparam int SqrtSteps = 33;     // root of a 66-bit radicand, one bit per step
    localparam int RadW = 66;          // square sum (34 bits) shifted up by 32
    localparam int RootW = 33;
    localparam int XW = 40;            // CORDIC x grows by about 1.65
    localparam int YW = 40;
    localparam int ZW = 34;

    typedef enum logic [2:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_FORWARD  = 3'd3,
        REG_RIGHT    = 3'd4,
        REG_UP       = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } angles_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } cfg_write_t;

    // Payload carried by one cell of the square root chain.
    typedef struct packed {
        logic              valid;
        logic [RadW-1:0]   rem;
        logic [RootW-1:0]  root;
        logic signed [16:0] num;
        logic              zero;
    } sqrt_cell_t;

    // Payload carried by one CORDIC cell.
    typedef struct packed {
        logic              valid;
        logic signed [XW-1:0] x;
        logic signed [YW-1:0] y;
        logic signed [ZW-1:0] z;
        logic              zero;
        logic signed [16:0] num;
    } cordic_cell_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
                3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
                9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
                12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
                15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
                18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
                21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_entry = signed'({{(ZW-32){1'b0}}, v});
        end
    endfunction

endpackage

FILE: rtl/core/atrp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the bit-serial integer square root.
// ----------------------------------------------------------------------------
module atrp_sqrt_cell
    import atrp_pkg::*;
#(
    parameter int Step = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sqrt_cell_t prev,
    output sqrt_cell_t step_out
);

    localparam int Bit = RootW - 1 - Step;

    logic              valid_reg;
    sqrt_cell_t        data_reg;
    sqrt_cell_t        data_next;
    logic [RadW+1:0]   trial;
    logic [RadW+1:0]   rem_ext;

    // Root bits are decided from the top down; the trial is (root << (Bit + 1)) | (1 << 2*Bit).
    always_comb
    begin
        data_next = prev;
        trial = ({{(RadW+2-RootW){1'b0}}, prev.root} << (Bit + 1))
              | ({{(RadW+1){1'b0}}, 1'b1} << (2 * Bit));
        rem_ext = {2'b00, prev.rem};
        if (rem_ext >= trial)
        begin
            data_next.rem = RadW'(rem_ext - trial);
            data_next.root = prev.root | (RootW'(1) << Bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= prev.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        step_out = data_reg;
        step_out.valid = valid_reg;
    end

endmodule

FILE: rtl/core/atrp_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation of the arctangent chain.
// ----------------------------------------------------------------------------
module atrp_cordic_cell
    import atrp_pkg::*;
#(
    parameter int Step = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cordic_cell_t prev,
    output cordic_cell_t step_out
);

    localparam logic signed [ZW-1:0] Atan = atan_entry(Step);

    logic         valid_reg;
    cordic_cell_t data_reg;
    cordic_cell_t data_next;

    always_comb
    begin
        data_next = prev;
        if (prev.y >= 0)
        begin
            data_next.x = prev.x + XW'(prev.y >>> Step);
            data_next.y = prev.y - YW'(prev.x >>> Step);
            data_next.z = prev.z + Atan;
        end
        else
        begin
            data_next.x = prev.x - XW'(prev.y >>> Step);
            data_next.y = prev.y + YW'(prev.x >>> Step);
            data_next.z = prev.z - Atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= prev.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        step_out = data_reg;
        step_out.valid = valid_reg;
    end

endmodule

FILE: rtl/core/atrp_tilt_chain.sv
// ----------------------------------------------------------------------------
// Tilt chain
// Square root cells followed by CORDIC cells for one tilt angle.
// ----------------------------------------------------------------------------
module atrp_tilt_chain
    import atrp_pkg::*;
#(
    parameter int CordicStages = CordicStagesDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [16:0] num,
    input  logic signed [16:0] a,
    input  logic signed [16:0] b,
    output logic               out_valid,
    output logic signed [15:0] angle
);

    sqrt_cell_t   sq [0:SqrtSteps];
    cordic_cell_t cc [0:CordicStages];
    logic [RadW-1:0] sum_sq;
    logic signed [ZW-1:0] z_round;
    logic signed [ZW-17:0] z_sh;

    always_comb
    begin
        sum_sq = {{(RadW-34){1'b0}}, 34'(a * a) + 34'(b * b)} << 32;
        sq[0].valid = in_valid;
        sq[0].rem = sum_sq;
        sq[0].root = '0;
        sq[0].num = num;
        sq[0].zero = (a == 0) && (b == 0);
    end

    for (genvar i = 0; i < SqrtSteps; i++)
    begin : g_sqrt
        atrp_sqrt_cell #(.Step(i)) u_cell (.clk(clk), .rst_n(rst_n), .prev(sq[i]),
                                            .step_out(sq[i+1]));
    end

    always_comb
    begin
        cc[0].valid = sq[SqrtSteps].valid;
        cc[0].x = signed'(XW'(sq[SqrtSteps].root));
        cc[0].y = YW'(sq[SqrtSteps].num) <<< 16;
        cc[0].z = '0;
        cc[0].zero = sq[SqrtSteps].zero;
        cc[0].num = sq[SqrtSteps].num;
    end

    for (genvar i = 0; i < CordicStages; i++)
    begin : g_cordic
        atrp_cordic_cell #(.Step(i)) u_cell (.clk(clk), .rst_n(rst_n), .prev(cc[i]),
                                              .step_out(cc[i+1]));
    end

    // Round to the nearest LSB, then clamp to a quarter turn; a zero root gives 0 or a quarter turn signed by num.
    always_comb
    begin
        z_round = cc[CordicStages].z + ZW'(32768);
        z_sh = z_round[ZW-1:16];
        if (cc[CordicStages].zero)
        begin
            if (cc[CordicStages].num == 0)
                angle = 16'sd0;
            else if (cc[CordicStages].num > 0)
                angle = 16'sd16384;
            else
                angle = -16'sd16384;
        end
        else if (z_sh > 16384)
            angle = 16'sd16384;
        else if (z_sh < -16384)
            angle = -16'sd16384;
        else
            angle = z_sh[15:0];
        out_valid = cc[CordicStages].valid;
    end

endmodule

FILE: rtl/core/accel_tilt_roll_pitch_core.sv
// ----------------------------------------------------------------------------
// Accelerometer roll and pitch core
// Offsets, axis mapping and two pipelined atan chains.
// ----------------------------------------------------------------------------
// A sample is taken in every cycle in which start is high; busy never rises.
// Each sample comes out on result with done high after passing the input
// register, the square root cells and then the CORDIC cells (one square root
// bit and one CORDIC rotation per cell). The receiver cannot stall;
// results must be captured the cycle done is high.
module accel_tilt_roll_pitch_core
    import atrp_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  sample_t    sample,
    output logic       done,
    output angles_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_write_t cfg
);

    logic [15:0] off_x_reg, off_y_reg, off_z_reg;
    logic [2:0]  fwd_sel_reg, right_sel_reg, up_sel_reg;
    logic        in_valid_reg;
    logic signed [16:0] f_reg, r_reg, u_reg;
    logic signed [15:0] ax, ay, az;
    logic signed [16:0] f_next, r_next, u_next;
    logic        pitch_valid, roll_valid;
    logic signed [15:0] pitch, roll;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            fwd_sel_reg <= 3'd0;
            right_sel_reg <= 3'd2;
            up_sel_reg <= 3'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg.index)
                REG_OFFSET_X: off_x_reg <= cfg.data;
                REG_OFFSET_Y: off_y_reg <= cfg.data;
                REG_OFFSET_Z: off_z_reg <= cfg.data;
                REG_FORWARD:  fwd_sel_reg <= cfg.data[2:0];
                REG_RIGHT:    right_sel_reg <= cfg.data[2:0];
                REG_UP:       up_sel_reg <= cfg.data[2:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [16:0] pick(input logic [2:0] sel,
        input logic signed [15:0] x, input logic signed [15:0] y,
        input logic signed [15:0] z);
        logic signed [15:0] v;
        begin
            case (sel[2:1])
                2'd0: v = x;
                2'd1: v = y;
                2'd2: v = z;
                default: v = '0;
            endcase
            if (sel[0])
                v = 16'(-v);
            pick = 17'(v);
        end
    endfunction

    always_comb
    begin
        ax = sample.accel_x + signed'(off_x_reg);
        ay = sample.accel_y + signed'(off_y_reg);
        az = sample.accel_z + signed'(off_z_reg);
        f_next = pick(fwd_sel_reg, ax, ay, az);
        r_next = pick(right_sel_reg, ax, ay, az);
        u_next = pick(up_sel_reg, ax, ay, az);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        r_reg <= r_next;
        u_reg <= u_next;
    end

    atrp_tilt_chain #(.CordicStages(CORDIC_STAGES)) u_pitch (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid_reg),
        .num(f_reg), .a(r_reg), .b(u_reg),
        .out_valid(pitch_valid), .angle(pitch));

    atrp_tilt_chain #(.CordicStages(CORDIC_STAGES)) u_roll (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid_reg),
        .num(r_reg), .a(f_reg), .b(u_reg),
        .out_valid(roll_valid), .angle(roll));

    assign done = pitch_valid & roll_valid;
    assign result.pitch_angle = pitch;
    assign result.roll_angle = roll;

endmodule

FILE: rtl/core/atrp_checker.sv
// ----------------------------------------------------------------------------
// Tilt core checker
// Port-level properties of the roll and pitch core.
// ----------------------------------------------------------------------------
module atrp_checker
    import atrp_pkg::*;
#(
    parameter int CordicStages = CordicStagesDefault
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input angles_t result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.pitch_angle <= 16384 && result.pitch_angle >= -16384))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.roll_angle <= 16384 && result.roll_angle >= -16384))
        else $error("roll out of range");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, SqrtSteps + CordicStages + 1))
        else $error("result without transaction");

endmodule

bind accel_tilt_roll_pitch_core atrp_checker #(.CordicStages(CORDIC_STAGES)) u_atrp_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result));

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Roll and pitch core testbench
// Drives random and corner accelerometer samples through the tilt core under
// several offset and axis mappings, and checks each pitch and roll result
// against a bit-accurate CORDIC angle predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import atrp_pkg::*;

    localparam int Stages = 16;
    localparam int Latency = SqrtSteps + Stages + 1;
    localparam longint CycleLimit = 400000;

    typedef struct {
        bit is_cfg;
        bit hold;
        sample_t smp;
        cfg_write_t wr;
    } job_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    sample_t    sample;
    logic       done;
    angles_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_write_t cfg;

    job_t       job_q[$];
    angles_t    angle_q[$];
    logic [15:0] offs[3] = '{16'd0, 16'd0, 16'd0};
    logic [2:0]  sel[3] = '{3'd0, 3'd2, 3'd4};
    int         errors = 0;
    longint     cycles = 0;
    bit         stim_done = 0;
    bit         calm = 0;
    int         drain_cnt = 0;

    accel_tilt_roll_pitch_core #(.CORDIC_STAGES(Stages)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg(cfg)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root64(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [15:0] tilt_angle(longint num, longint a, longint b);
        longint unsigned sq;
        longint x, y, z, nx;
        sq = longint'(a * a) + longint'(b * b);
        z = 0;
        if (sq == 0)
            return (num == 0) ? 16'd0 : (num > 0 ? 16'sd16384 : -16'sd16384);
        x = root64(sq << 32);
        y = num * 65536;
        for (int i = 0; i < Stages && i < AtanTableLen; i++)
        begin
            if (y >= 0)
            begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                z += longint'(atan_entry(i));
            end
            else
            begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                z -= longint'(atan_entry(i));
            end
            x = nx;
        end
        z = shr(z + 32768, 16);
        if (z > 16384)
            z = 16384;
        if (z < -16384)
            z = -16384;
        return z[15:0];
    endfunction

    function automatic longint map_axis(logic [2:0] s, logic [15:0] ax[3]);
        logic [15:0] v;
        if (s[2:1] == 2'd3)
            return 0;
        v = ax[s[2:1]];
        if (s[0])
            v = -v;
        return longint'($signed(v));
    endfunction

    function automatic angles_t predict_angles(sample_t s);
        logic [15:0] ax[3];
        longint f, r, u;
        angles_t a;
        ax[0] = s.accel_x + offs[0];
        ax[1] = s.accel_y + offs[1];
        ax[2] = s.accel_z + offs[2];
        f = map_axis(sel[0], ax);
        r = map_axis(sel[1], ax);
        u = map_axis(sel[2], ax);
        a.pitch_angle = tilt_angle(f, r, u);
        a.roll_angle = tilt_angle(r, f, u);
        return a;
    endfunction

    task automatic push_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        job_t j;
        j.is_cfg = 0;
        j.hold = 0;
        j.smp = '{accel_x: x, accel_y: y, accel_z: z};
        j.wr = '0;
        job_q.push_back(j);
    endtask

    task automatic push_cfg(reg_index_t idx, logic [15:0] d);
        job_t j;
        j.is_cfg = 1;
        j.hold = 0;
        j.smp = '0;
        j.wr = '{index: idx, data: d};
        job_q.push_back(j);
    endtask

    task automatic push_hold();
        job_t j;
        j = '{default: 0};
        j.hold = 1;
        job_q.push_back(j);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 64)) - 32);
            4: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Config writes go out only once all results are in and the pipe has drained.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            sample <= '0;
            cfg_valid <= 1'b0;
            cfg <= '0;
            drain_cnt <= 0;
        end
        else
        begin
            logic fire_s;
            logic fire_c;
            fire_s = start && !busy;
            fire_c = cfg_valid && cfg_ready;
            if (fire_s)
            begin
                angle_q.push_back(predict_angles(sample));
                void'(job_q.pop_front());
            end
            if (fire_c)
            begin
                if (cfg.index <= REG_OFFSET_Z)
                    offs[cfg.index] = cfg.data;
                else
                    sel[cfg.index - REG_FORWARD] = cfg.data[2:0];
                void'(job_q.pop_front());
            end
            if (angle_q.size() != 0 || fire_s)
                drain_cnt <= 0;
            else if (drain_cnt < Latency + 4)
                drain_cnt <= drain_cnt + 1;
            if (job_q.size() == 0)
            begin
                start <= 1'b0;
                cfg_valid <= 1'b0;
                stim_done <= 1;
            end
            else if (job_q[0].hold)
            begin
                start <= 1'b0;
                cfg_valid <= 1'b0;
                if (!fire_s && angle_q.size() == 0)
                    void'(job_q.pop_front());
            end
            else if (job_q[0].is_cfg)
            begin
                start <= 1'b0;
                if (fire_c)
                    cfg_valid <= 1'b0;
                else if (drain_cnt >= Latency + 4 && !fire_s)
                begin
                    cfg_valid <= 1'b1;
                    cfg <= job_q[0].wr;
                end
            end
            else
            begin
                cfg_valid <= 1'b0;
                if (calm || $urandom_range(0, 99) >= 27)
                begin
                    start <= 1'b1;
                    sample <= job_q[0].smp;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && done)
        begin
            if (angle_q.size() == 0)
            begin
                $error("result with no sample pending: %h", result);
                errors++;
            end
            else
            begin
                want = angle_q.pop_front();
                if (result.pitch_angle !== want.pitch_angle)
                begin
                    $error("pitch_angle expected %0d actual %0d",
                           want.pitch_angle, result.pitch_angle);
                    errors++;
                end
                if (result.roll_angle !== want.roll_angle)
                begin
                    $error("roll_angle expected %0d actual %0d",
                           want.roll_angle, result.roll_angle);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            push_sample(rand_field(), rand_field(), rand_field());
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, zero root cases and the self-negating minimum.
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_sample(16'h0100, 16'h0000, 16'h0000);
        push_sample(16'hFF00, 16'h0000, 16'h0000);
        push_sample(16'h0000, 16'h0100, 16'h0000);
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_sample(16'h8000, 16'h8000, 16'h8000);
        push_sample(16'h8000, 16'h7FFF, 16'h0001);
        push_sample(16'h0000, 16'h0000, 16'h4000);
        push_sample(16'h0001, 16'hFFFF, 16'h0001);
        push_sample(16'h1234, 16'hEDCC, 16'h0F00);
        push_cfg(REG_FORWARD, 16'd1);
        push_cfg(REG_RIGHT, 16'd3);
        push_cfg(REG_UP, 16'd5);
        push_sample(16'h8000, 16'h0000, 16'h0000);
        push_sample(16'h8000, 16'h8000, 16'h0000);
        push_cfg(REG_FORWARD, 16'd6);
        push_cfg(REG_RIGHT, 16'd7);
        push_sample(16'h0000, 16'h0000, 16'h1000);
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_cfg(REG_OFFSET_X, 16'h8000);
        push_cfg(REG_OFFSET_Y, 16'h7FFF);
        push_cfg(REG_OFFSET_Z, 16'hFFFF);
        push_cfg(REG_FORWARD, 16'd0);
        push_cfg(REG_RIGHT, 16'd2);
        push_cfg(REG_UP, 16'd4);
        push_sample(16'h8000, 16'h0001, 16'h0001);
        push_sample(16'h0000, 16'h8001, 16'h7FFF);
        push_sample(16'h7FFF, 16'hFFFF, 16'h8000);

        random_phase(300);
        push_hold();
        for (int p = 0; p < 5; p++)
        begin
            push_cfg(REG_OFFSET_X, (p == 0) ? 16'h0000 : 16'($urandom));
            push_cfg(REG_OFFSET_Y, (p == 1) ? 16'h7FFF : 16'($urandom_range(0, 255)));
            push_cfg(REG_OFFSET_Z, (p == 2) ? 16'h8000 : 16'($urandom));
            push_cfg(REG_FORWARD, 16'($urandom_range(0, 7)));
            push_cfg(REG_RIGHT, 16'($urandom_range(0, 7)));
            push_cfg(REG_UP, 16'($urandom_range(0, 7)));
            random_phase(210);
        end

        wait (job_q.size() < 400);
        calm = 1;
        wait (job_q.size() < 200);
        calm = 0;
        wait (stim_done && job_q.size() == 0);
        wait (angle_q.size() == 0);
        repeat (Latency + 10) @(posedge clk);
        if (errors == 0 && angle_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
